// ----- rtl/wss_pkg.sv -----
// Shared types, constants and tables for the waypoint steering block.
`timescale 1ns / 1ps
`default_nettype none
package wss_pkg;

  localparam int MaxWaypoints = 256;
  localparam int CoordWidth   = 32;
  localparam int AngleWidth   = 16;
  localparam int CordicSteps  = 16;
  localparam int StepW        = 4;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic [1:0] REG_COUNT = 2'd0;
  localparam logic [1:0] REG_PROX  = 2'd1;
  localparam logic [1:0] REG_STEP  = 2'd2;
  localparam logic [1:0] REG_GAIN  = 2'd3;

  localparam logic signed [34:0] CordicK30 = 35'sd652032874;

  // atan(2^-i) in 2^32-per-turn units
  function automatic logic [31:0] arc_of(input logic [StepW-1:0] i);
    logic [31:0] r;
    begin
      case (i)
        4'd0:  r = 32'd536870912;
        4'd1:  r = 32'd316933406;
        4'd2:  r = 32'd167458907;
        4'd3:  r = 32'd85004756;
        4'd4:  r = 32'd42667331;
        4'd5:  r = 32'd21354465;
        4'd6:  r = 32'd10679838;
        4'd7:  r = 32'd5340245;
        4'd8:  r = 32'd2670163;
        4'd9:  r = 32'd1335087;
        4'd10: r = 32'd667544;
        4'd11: r = 32'd333772;
        4'd12: r = 32'd166886;
        4'd13: r = 32'd83443;
        4'd14: r = 32'd41722;
        default: r = 32'd20861;
      endcase
      return r;
    end
  endfunction

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture input beat
    logic wr_tab;    // store waypoint
    logic rd_tab;    // read target waypoint
    logic start;     // place point on waypoint 0
    logic rd_zero;   // read waypoint 0
    logic prep;      // compute deltas, reach test, init bearing CORDIC
    logic vec_step;  // one vectoring iteration
    logic steer;     // error times gain
    logic rot_init;  // update heading, init rotation CORDIC
    logic rot_step;  // one rotation iteration
    logic mul;       // step times sin/cos
    logic move;      // update position
    logic quiet;     // result with zero turn and no reach
  } wss_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       iter_last;
  } wss_sts_t;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_RD    = 12'b000000000010,
    ST_PREP  = 12'b000000000100,
    ST_VEC   = 12'b000000001000,
    ST_STEER = 12'b000000010000,
    ST_ROTI  = 12'b000000100000,
    ST_ROT   = 12'b000001000000,
    ST_MUL   = 12'b000010000000,
    ST_MOVE  = 12'b000100000000,
    ST_OUT   = 12'b001000000000,
    ST_START = 12'b010000000000,
    ST_QUIET = 12'b100000000000
  } wss_state_e;

endpackage
`default_nettype wire

// ----- rtl/wss_ctrl.sv -----
// Sequencer for one item: table access, two CORDIC runs, scaling, move.
`timescale 1ns / 1ps
`default_nettype none
module wss_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              out_busy_i,
  output logic                   out_push_o,
  input  wire wss_pkg::wss_sts_t sts_i,
  output wss_pkg::wss_cmd_t      cmd_o
);

  wss_pkg::wss_state_e state_q, state_d;

  assign in_ready_o = (state_q == wss_pkg::ST_IDLE);

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    out_push_o = 1'b0;
    case (state_q)
      wss_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = wss_pkg::ST_RD;
        end
      end
      wss_pkg::ST_RD: begin
        case (sts_i.kind)
          wss_pkg::KIND_WRITE: begin
            cmd_o.wr_tab = 1'b1;
            state_d      = wss_pkg::ST_QUIET;
          end
          wss_pkg::KIND_START: begin
            cmd_o.rd_zero = 1'b1;
            state_d       = wss_pkg::ST_START;
          end
          wss_pkg::KIND_TICK: begin
            cmd_o.rd_tab = 1'b1;
            state_d      = wss_pkg::ST_PREP;
          end
          default: state_d = wss_pkg::ST_QUIET;
        endcase
      end
      wss_pkg::ST_START: begin
        cmd_o.start = 1'b1;
        state_d     = wss_pkg::ST_OUT;
      end
      wss_pkg::ST_QUIET: begin
        cmd_o.quiet = 1'b1;
        state_d     = wss_pkg::ST_OUT;
      end
      wss_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = wss_pkg::ST_VEC;
      end
      wss_pkg::ST_VEC: begin
        cmd_o.vec_step = 1'b1;
        if (sts_i.iter_last) state_d = wss_pkg::ST_STEER;
      end
      wss_pkg::ST_STEER: begin
        cmd_o.steer = 1'b1;
        state_d     = wss_pkg::ST_ROTI;
      end
      wss_pkg::ST_ROTI: begin
        cmd_o.rot_init = 1'b1;
        state_d        = wss_pkg::ST_ROT;
      end
      wss_pkg::ST_ROT: begin
        cmd_o.rot_step = 1'b1;
        if (sts_i.iter_last) state_d = wss_pkg::ST_MUL;
      end
      wss_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = wss_pkg::ST_MOVE;
      end
      wss_pkg::ST_MOVE: begin
        cmd_o.move = 1'b1;
        state_d    = wss_pkg::ST_OUT;
      end
      wss_pkg::ST_OUT: begin
        // hold until the output register is free
        if (!out_busy_i) begin
          out_push_o = 1'b1;
          state_d    = wss_pkg::ST_IDLE;
        end
      end
      default: state_d = wss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wss_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_push_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> state_q == wss_pkg::ST_OUT)
    else $error("push outside output state");
  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |=> in_ready_o)
    else $error("no return to idle after push");
`endif

endmodule
`default_nettype wire

// ----- rtl/wss_datapath.sv -----
// Datapath: waypoint memory, state registers, shared CORDIC and multipliers.
`timescale 1ns / 1ps
`default_nettype none
module wss_datapath #(
  parameter int MAX_WAYPOINTS = wss_pkg::MaxWaypoints,
  parameter int COORD_WIDTH   = wss_pkg::CoordWidth,
  parameter int ANGLE_WIDTH   = wss_pkg::AngleWidth,
  localparam int IdxW = $clog2(MAX_WAYPOINTS)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire wss_pkg::wss_cmd_t      cmd_i,
  output wss_pkg::wss_sts_t           sts_o,
  input  wire logic [1:0]             kind_i,
  input  wire logic [7:0]             wp_index_i,
  input  wire logic [COORD_WIDTH-1:0] wp_x_i,
  input  wire logic [COORD_WIDTH-1:0] wp_y_i,
  input  wire logic [8:0]             count_i,
  input  wire logic [30:0]            prox_i,
  input  wire logic [30:0]            step_i,
  input  wire logic [15:0]            gain_i,
  output logic [COORD_WIDTH-1:0]      pos_x_o,
  output logic [COORD_WIDTH-1:0]      pos_y_o,
  output logic [ANGLE_WIDTH-1:0]      heading_o,
  output logic [ANGLE_WIDTH-1:0]      turn_o,
  output logic [7:0]                  target_o,
  output logic                        reached_o
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;          // delta width
  localparam int VW = CW + 4;          // vectoring width with growth
  localparam int AW = ANGLE_WIDTH;
  localparam int RW = 35;              // rotation width
  localparam int SW = wss_pkg::StepW;
  localparam logic [SW-1:0] LastIter = SW'(wss_pkg::CordicSteps - 1);

  logic [2*CW-1:0] mem_q [MAX_WAYPOINTS];
  logic [2*CW-1:0] rd_q;

  logic [1:0]          kind_q;
  logic [7:0]          idx_q;
  logic [CW-1:0]       wx_q, wy_q;
  logic [CW-1:0]       px_q, py_q;
  logic [AW-1:0]       head_q, turn_q;
  logic [IdxW-1:0]     tgt_q;
  logic                reach_q, zero_q;
  logic signed [VW-1:0] u_q, v_q;
  logic [31:0]         z_q;
  logic signed [RW-1:0] c_q, s_q;
  logic                flip_q;
  logic [SW-1:0]       it_q;
  logic signed [65:0]  ms_q, mc_q;

  logic [IdxW-1:0] tgt_rd;

  assign tgt_rd = tgt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_tab && (32'(idx_q) < 32'(MAX_WAYPOINTS))) begin
      mem_q[IdxW'(idx_q)] <= {wy_q, wx_q};
    end
    if (cmd_i.rd_tab) rd_q <= mem_q[tgt_rd];
    else if (cmd_i.rd_zero) rd_q <= mem_q[0];
  end

  // Reach test and deltas
  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]        mx, my;
  logic [2*DW-1:0]      sq;
  logic                 near;
  logic [8:0]           cnt_eff;
  logic [IdxW:0]        tgt_inc;

  always_comb begin
    dx = $signed({rd_q[CW-1], rd_q[CW-1:0]}) - $signed({px_q[CW-1], px_q});
    dy = $signed({rd_q[2*CW-1], rd_q[2*CW-1:CW]}) - $signed({py_q[CW-1], py_q});
    mx = dx[DW-1] ? DW'(-dx) : DW'(dx);
    my = dy[DW-1] ? DW'(-dy) : DW'(dy);
    sq = (2*DW)'(mx * mx) + (2*DW)'(my * my);
    near = (mx < DW'(prox_i)) && (my < DW'(prox_i)) &&
           (sq < (2*DW)'({31'd0, prox_i} * {31'd0, prox_i}));
    cnt_eff = (count_i == 9'd0) ? 9'd1 : count_i;
    if (32'(cnt_eff) > 32'(MAX_WAYPOINTS)) cnt_eff = 9'(MAX_WAYPOINTS);
    tgt_inc = {1'b0, tgt_q} + 1'b1;
  end

  // Vectoring step
  logic signed [VW-1:0] u_sh, v_sh;
  assign u_sh = u_q >>> it_q;
  assign v_sh = v_q >>> it_q;

  // Steering
  logic [AW-1:0]        bear, err;
  logic signed [AW+17:0] prod;
  logic [31:0]          zr;
  always_comb begin
    zr   = z_q + (32'd1 << (31 - AW));
    bear = zero_q ? (AW'(1) << (AW - 1)) : zr[31 -: AW];
    err  = bear - head_q;
    prod = $signed({1'b0, gain_i}) * $signed(err) + $signed((AW+18)'(32768));
  end

  // Rotation init
  logic [AW-1:0]        hnew;
  logic [31:0]          a32;
  logic signed [32:0]   za;
  assign hnew = head_q + turn_q;
  assign a32  = {hnew, (32-AW)'(0)};
  assign za   = $signed({a32[31], a32});

  logic signed [RW-1:0] c_sh, s_sh;
  assign c_sh = c_q >>> it_q;
  assign s_sh = s_q >>> it_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q    <= '0;
      py_q    <= '0;
      head_q  <= '0;
      turn_q  <= '0;
      tgt_q   <= '0;
      reach_q <= 1'b0;
      it_q    <= '0;
      kind_q  <= '0;
      idx_q   <= '0;
      wx_q    <= '0;
      wy_q    <= '0;
      zero_q  <= 1'b0;
      u_q     <= '0;
      v_q     <= '0;
      z_q     <= '0;
      c_q     <= '0;
      s_q     <= '0;
      flip_q  <= 1'b0;
      ms_q    <= '0;
      mc_q    <= '0;
    end else begin
      if (cmd_i.load) begin
        kind_q <= kind_i;
        idx_q  <= wp_index_i;
        wx_q   <= wp_x_i;
        wy_q   <= wp_y_i;
      end
      if (cmd_i.quiet) begin
        turn_q  <= '0;
        reach_q <= 1'b0;
      end
      if (cmd_i.start) begin
        px_q    <= rd_q[CW-1:0];
        py_q    <= rd_q[2*CW-1:CW];
        head_q  <= '0;
        tgt_q   <= '0;
        turn_q  <= '0;
        reach_q <= 1'b0;
      end
      if (cmd_i.prep) begin
        reach_q <= near;
        if (near) tgt_q <= (32'(tgt_inc) >= 32'(cnt_eff)) ? '0 : tgt_inc[IdxW-1:0];
        zero_q <= (dx == '0) && (dy == '0);
        it_q   <= '0;
        // half-turn pre-rotation when -dy is negative
        if (dy > 0) begin
          u_q <= VW'(dy);
          v_q <= VW'(-dx);
          z_q <= 32'h8000_0000;
        end else begin
          u_q <= VW'(-dy);
          v_q <= VW'(dx);
          z_q <= '0;
        end
      end
      if (cmd_i.vec_step) begin
        it_q <= it_q + 1'b1;
        if (!v_q[VW-1]) begin
          u_q <= u_q + v_sh;
          v_q <= v_q - u_sh;
          z_q <= z_q + wss_pkg::arc_of(it_q);
        end else begin
          u_q <= u_q - v_sh;
          v_q <= v_q + u_sh;
          z_q <= z_q - wss_pkg::arc_of(it_q);
        end
      end
      if (cmd_i.steer) turn_q <= prod[AW+15:16];
      if (cmd_i.rot_init) begin
        head_q <= hnew;
        it_q   <= '0;
        c_q    <= wss_pkg::CordicK30;
        s_q    <= '0;
        if (za > 33'sd1073741824) begin
          z_q <= 32'(za - 33'sh0_8000_0000);
          flip_q <= 1'b1;
        end else if (za < -33'sd1073741824) begin
          z_q <= 32'(za + 33'sh0_8000_0000);
          flip_q <= 1'b1;
        end else begin
          z_q <= 32'(za);
          flip_q <= 1'b0;
        end
      end
      if (cmd_i.rot_step) begin
        it_q <= it_q + 1'b1;
        if (!z_q[31]) begin
          c_q <= c_q - s_sh;
          s_q <= s_q + c_sh;
          z_q <= z_q - wss_pkg::arc_of(it_q);
        end else begin
          c_q <= c_q + s_sh;
          s_q <= s_q - c_sh;
          z_q <= z_q + wss_pkg::arc_of(it_q);
        end
      end
      if (cmd_i.mul) begin
        ms_q <= $signed({1'b0, step_i}) * (flip_q ? -s_q : s_q) + 66'sd536870912;
        mc_q <= $signed({1'b0, step_i}) * (flip_q ? -c_q : c_q) + 66'sd536870912;
      end
      if (cmd_i.move) begin
        px_q <= px_q + CW'(ms_q >>> 30);
        py_q <= py_q - CW'(mc_q >>> 30);
      end
    end
  end

  assign sts_o.kind      = kind_q;
  assign sts_o.iter_last = (it_q == LastIter);

  assign pos_x_o   = px_q;
  assign pos_y_o   = py_q;
  assign heading_o = head_q;
  assign turn_o    = turn_q;
  assign target_o  = 8'(tgt_q);
  assign reached_o = reach_q;

`ifndef ASSERT_OFF
  a_tgt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(tgt_q) < 32'(MAX_WAYPOINTS))
    else $error("target index out of range");
  a_start_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |=> head_q == '0 && tgt_q == '0 && turn_q == '0)
    else $error("start did not clear state");
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.quiet |=> !reach_q && turn_q == '0)
    else $error("quiet item changed turn or reach");
`endif

endmodule
`default_nettype wire

// ----- rtl/waypoint_steering_step.sv -----
// Top level: stream ports, APB registers, controller, datapath, output register.
`timescale 1ns / 1ps
`default_nettype none
// Steers a point around a closed loop of waypoints. Each input beat (write
// waypoint, start, tick) yields one result beat. A tick runs two 16-iteration
// CORDIC runs (bearing, then sine/cosine) that share one iteration counter
// and angle register, plus table read, reach test, steering and scaling steps.
// A new beat is taken once the previous result sits in the output register.
module waypoint_steering_step #(
  parameter int MAX_WAYPOINTS = wss_pkg::MaxWaypoints,
  parameter int COORD_WIDTH   = wss_pkg::CoordWidth,
  parameter int ANGLE_WIDTH   = wss_pkg::AngleWidth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // wp_index, wp_x, wp_y
  input  wire logic [1:0]  s_axis_tuser,  // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [103:0]     m_axis_tdata,  // pos_x, pos_y, heading_out, turn_rate, target_out
  output logic             m_axis_tuser,  // reached
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  wss_pkg::wss_cmd_t cmd;
  wss_pkg::wss_sts_t sts;
  logic push;

  logic [8:0]  count_q;
  logic [30:0] prox_q, step_q;
  logic [15:0] gain_q;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 9'd1;
      prox_q  <= 31'd256;
      step_q  <= 31'd256;
      gain_q  <= 16'd16384;
    end else if (wr) begin
      case (paddr[3:2])
        wss_pkg::REG_COUNT: count_q <= pwdata[8:0];
        wss_pkg::REG_PROX:  prox_q  <= pwdata[30:0];
        wss_pkg::REG_STEP:  step_q  <= pwdata[30:0];
        wss_pkg::REG_GAIN:  gain_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      wss_pkg::REG_COUNT: prdata = {23'd0, count_q};
      wss_pkg::REG_PROX:  prdata = {1'b0, prox_q};
      wss_pkg::REG_STEP:  prdata = {1'b0, step_q};
      wss_pkg::REG_GAIN:  prdata = {16'd0, gain_q};
      default:            prdata = '0;
    endcase
  end

  wss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_busy_i (m_axis_tvalid && !m_axis_tready),
    .out_push_o (push),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  logic [COORD_WIDTH-1:0] px, py;
  logic [ANGLE_WIDTH-1:0] hd, tr;
  logic [7:0]             tg;
  logic                   rc;

  wss_datapath #(
    .MAX_WAYPOINTS (MAX_WAYPOINTS),
    .COORD_WIDTH   (COORD_WIDTH),
    .ANGLE_WIDTH   (ANGLE_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .kind_i     (s_axis_tuser),
    .wp_index_i (s_axis_tdata[7:0]),
    .wp_x_i     (COORD_WIDTH'(s_axis_tdata[39:8])),
    .wp_y_i     (COORD_WIDTH'(s_axis_tdata[71:40])),
    .count_i    (count_q),
    .prox_i     (prox_q),
    .step_i     (step_q),
    .gain_i     (gain_q),
    .pos_x_o    (px),
    .pos_y_o    (py),
    .heading_o  (hd),
    .turn_o     (tr),
    .target_o   (tg),
    .reached_o  (rc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (push) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      m_axis_tdata <= {tg, 16'(tr), 16'(hd), 32'(py), 32'(px)};
      m_axis_tuser <= rc;
    end
  end

`ifndef ASSERT_OFF
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("result overwritten");
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second beat taken while busy");
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

// ----- tb/waypoint_steering_step_test.sv -----
// Self-checking bench for the waypoint steering block: stream driver, monitor, APB setup.
`timescale 1ns / 1ps
module waypoint_steering_step_test;

  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef struct {
    logic [1:0]         kind;
    logic [7:0]         idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } wp_item_t;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    logic signed [15:0] turn;
    logic [7:0]         target;
    logic               reached;
  } nav_result_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [71:0]   s_axis_tdata = '0;  // wp_index, wp_x, wp_y
  logic [1:0]    s_axis_tuser = '0;  // kind
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [103:0]  m_axis_tdata;       // pos_x, pos_y, heading_out, turn_rate, target_out
  logic          m_axis_tuser;       // reached
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [3:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  waypoint_steering_step dut (.*);

  // heading/track state mirrored from the block
  logic signed [31:0] nav_x, nav_y;
  logic [15:0]        nav_heading;
  logic [7:0]         nav_target;
  logic signed [31:0] tab_x [256];
  logic signed [31:0] tab_y [256];
  logic [8:0]         cfg_count = 9'd1;
  logic [30:0]        cfg_prox = 31'd256;
  logic [30:0]        cfg_step = 31'd256;
  logic [15:0]        cfg_gain = 16'd16384;

  longint arc_tab [16] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                           10679838, 5340245, 2670163, 1335087, 667544, 333772,
                           166886, 83443, 41722, 20861};

  wp_item_t    pending_items [$];
  nav_result_t expected_nav [$];
  int          errors = 0;
  int          in_beats = 0;
  int          out_beats = 0;
  int          hold_left = 0;
  bit          held = 1'b0;
  wire         calm = (in_beats >= 420 && in_beats < 520);

  initial forever #5 clk_i = ~clk_i;

  function automatic logic [15:0] bearing_of(longint dx, longint dy);
    longint u, v, z, nu;
    logic [31:0] zr;
    u = -dy;
    v = dx;
    z = 0;
    if (u == 0 && v == 0) return 16'h8000;
    if (u < 0) begin
      u = -u;
      v = -v;
      z = 64'sd2147483648;
    end
    for (int i = 0; i < 16; i++) begin
      if (v >= 0) begin
        nu = u + (v >>> i);
        v = v - (u >>> i);
        z += arc_tab[i];
      end else begin
        nu = u - (v >>> i);
        v = v + (u >>> i);
        z -= arc_tab[i];
      end
      u = nu;
    end
    zr = 32'(z + 32768);
    return zr[31:16];
  endfunction

  task automatic sin_cos_of(input logic [15:0] h, output longint s, output longint c);
    longint z, nc;
    bit flip;
    z = longint'({h, 16'h0000});
    flip = 1'b0;
    if (z >= 64'sd2147483648) z -= 64'sd4294967296;
    c = 652032874;
    s = 0;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      flip = 1'b1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nc = c - (s >>> i);
        s = s + (c >>> i);
        z -= arc_tab[i];
      end else begin
        nc = c + (s >>> i);
        s = s - (c >>> i);
        z += arc_tab[i];
      end
      c = nc;
    end
    if (flip) begin
      c = -c;
      s = -s;
    end
  endtask

  task automatic advance_nav(input wp_item_t it);
    nav_result_t r;
    longint dx, dy, mx, my, p, err, turn, sv, cv;
    int cnt;
    logic [15:0] b, diff;
    turn = 0;
    r.reached = 1'b0;
    case (it.kind)
      wss_pkg::KIND_WRITE: begin
        tab_x[it.idx] = it.x;
        tab_y[it.idx] = it.y;
      end
      wss_pkg::KIND_START: begin
        nav_target = 8'd0;
        nav_x = tab_x[0];
        nav_y = tab_y[0];
        nav_heading = 16'd0;
      end
      wss_pkg::KIND_TICK: begin
        dx = longint'(tab_x[nav_target]) - longint'(nav_x);
        dy = longint'(tab_y[nav_target]) - longint'(nav_y);
        p = longint'(cfg_prox);
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        cnt = int'(cfg_count);
        if (cnt == 0) cnt = 1;
        if (cnt > 256) cnt = 256;
        b = bearing_of(dx, dy);
        if (mx < p && my < p && mx * mx + my * my < p * p) begin
          nav_target = (int'(nav_target) + 1 >= cnt) ? 8'd0 : nav_target + 8'd1;
          r.reached = 1'b1;
        end
        diff = b - nav_heading;
        err = longint'($signed(diff));
        turn = (longint'(cfg_gain) * err + 32768) >>> 16;
        nav_heading = nav_heading + turn[15:0];
        sin_cos_of(nav_heading, sv, cv);
        nav_x = nav_x + 32'(((longint'(cfg_step) * sv) + (64'sd1 << 29)) >>> 30);
        nav_y = nav_y - 32'(((longint'(cfg_step) * cv) + (64'sd1 << 29)) >>> 30);
      end
      default: ;
    endcase
    r.pos_x = nav_x;
    r.pos_y = nav_y;
    r.heading = nav_heading;
    r.turn = turn[15:0];
    r.target = nav_target;
    expected_nav.insert(expected_nav.size(), r);
  endtask

  // driver: advance to the next pending beat once the current one is taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) in_beats <= in_beats + 1;
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 8)) begin
          wp_item_t it;
          it = pending_items.pop_front();
          advance_nav(it);
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= it.kind;
          s_axis_tdata <= {it.y, it.x, it.idx};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver readiness, with one long hold-off to back the block up
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!held && out_beats == 300) begin
        held <= 1'b1;
        hold_left <= 400;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at beat %0d: %s got %0d expected %0d", out_beats, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      nav_result_t w;
      out_beats <= out_beats + 1;
      if (expected_nav.size() == 0) begin
        report_mismatch("unexpected beat", out_beats, 0);
      end else begin
        w = expected_nav.pop_front();
        if ($signed(m_axis_tdata[31:0]) !== w.pos_x)
          report_mismatch("pos_x", $signed(m_axis_tdata[31:0]), w.pos_x);
        if ($signed(m_axis_tdata[63:32]) !== w.pos_y)
          report_mismatch("pos_y", $signed(m_axis_tdata[63:32]), w.pos_y);
        if (m_axis_tdata[79:64] !== w.heading)
          report_mismatch("heading", m_axis_tdata[79:64], w.heading);
        if ($signed(m_axis_tdata[95:80]) !== w.turn)
          report_mismatch("turn_rate", $signed(m_axis_tdata[95:80]), w.turn);
        if (m_axis_tdata[103:96] !== w.target)
          report_mismatch("target", m_axis_tdata[103:96], w.target);
        if (m_axis_tuser !== w.reached)
          report_mismatch("reached", m_axis_tuser, w.reached);
      end
    end
  end

  task automatic push_item(input logic [1:0] k, input logic [7:0] i,
                           input logic [31:0] x, input logic [31:0] y);
    wp_item_t it;
    it.kind = k;
    it.idx = i;
    it.x = x;
    it.y = y;
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic logic [31:0] pick_coord();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 10240)) - 5120);
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || expected_nav.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] r, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      wss_pkg::REG_COUNT: cfg_count = val[8:0];
      wss_pkg::REG_PROX:  cfg_prox = val[30:0];
      wss_pkg::REG_STEP:  cfg_step = val[30:0];
      default:            cfg_gain = val[15:0];
    endcase
  endtask

  task automatic set_regs(input logic [31:0] c, input logic [31:0] p,
                          input logic [31:0] s, input logic [31:0] g);
    drain();
    apb_write(wss_pkg::REG_COUNT, c);
    apb_write(wss_pkg::REG_PROX, p);
    apb_write(wss_pkg::REG_STEP, s);
    apb_write(wss_pkg::REG_GAIN, g);
  endtask

  initial begin
    logic [31:0] phase_cfg [6][4];
    int roll;
    nav_x = 0;
    nav_y = 0;
    nav_heading = 0;
    nav_target = 0;
    phase_cfg = '{'{4, 768, 256, 16384}, '{256, 32'h7fffffff, 32'h7fffffff, 65535},
                  '{0, 0, 0, 0}, '{511, 3000, 512, 40000}, '{2, 1024, 128, 8000},
                  '{3, 32'hffffffff, 300, 65535}};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extreme coordinates, unused kind, coincident target
    push_item(wss_pkg::KIND_WRITE, 8'd0, 32'h7fffffff, 32'h80000000);
    push_item(wss_pkg::KIND_WRITE, 8'd255, 32'h80000000, 32'h7fffffff);
    push_item(KIND_NONE, 8'hff, 32'hffffffff, 32'hffffffff);
    push_item(wss_pkg::KIND_START, 8'hff, 32'hffffffff, 32'hffffffff);
    push_item(wss_pkg::KIND_TICK, 8'h00, 32'h0, 32'h0);
    push_item(wss_pkg::KIND_WRITE, 8'd0, 32'h0, 32'h0);
    push_item(wss_pkg::KIND_TICK, 8'h00, 32'h0, 32'h0);
    push_item(wss_pkg::KIND_START, 8'h00, 32'h0, 32'h0);
    push_item(wss_pkg::KIND_TICK, 8'h00, 32'h0, 32'h0);
    push_item(wss_pkg::KIND_TICK, 8'h00, 32'h0, 32'h0);
    // hold the sender until all results are back
    drain();

    for (int i = 0; i < 256; i++)
      push_item(wss_pkg::KIND_WRITE, 8'(i), pick_coord(), pick_coord());

    for (int ph = 0; ph < 6; ph++) begin
      set_regs(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2], phase_cfg[ph][3]);
      push_item(wss_pkg::KIND_START, 8'($urandom), $urandom, $urandom);
      for (int n = 0; n < 70; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 85)
          push_item(wss_pkg::KIND_TICK, 8'($urandom), $urandom, $urandom);
        else if (roll < 90)
          push_item(wss_pkg::KIND_WRITE, 8'($urandom), pick_coord(), pick_coord());
        else if (roll < 95)
          push_item(KIND_NONE, 8'($urandom), $urandom, $urandom);
        else
          push_item(wss_pkg::KIND_START, 8'($urandom), $urandom, $urandom);
      end
    end

    drain();
    repeat (60) @(posedge clk_i);
    if (errors == 0 && expected_nav.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- waypoint_steering_step.f -----
rtl/wss_pkg.sv
rtl/wss_ctrl.sv
rtl/wss_datapath.sv
rtl/waypoint_steering_step.sv
tb/waypoint_steering_step_test.sv
